@@ rtl/tmph_pkg.sv @@
// Shared constants, types and register codes for the trimmed-mean pH converter.
package tmph_pkg;

  // Batch geometry and sample format
  localparam int BATCH_SIZE    = 10;
  localparam int TRIM_EACH_END = 2;
  localparam int SAMPLE_BITS   = 12;

  // Counter and accumulator widths follow from the batch geometry
  localparam int CNT_W = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
  localparam int SUM_W = SAMPLE_BITS + $clog2(BATCH_SIZE + 1);

  // Window of sorted positions that are summed
  localparam int KEEP_LO = TRIM_EACH_END;
  localparam int KEEP_HI = BATCH_SIZE - TRIM_EACH_END;

  // Port widths fixed by the interface
  localparam int IN_W     = 12;
  localparam int OUT_SUM_W = 15;
  localparam int PH_W     = 12;
  localparam int SLOPE_W  = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 16;

  localparam logic [31:0] SUM_MAX = 32'd32767;
  localparam logic [31:0] ROUND_HALF = 32'd32768;

  // Register reset values
  localparam logic [PH_W-1:0]    OFFSET_RST = 12'd2134;
  localparam logic [SLOPE_W-1:0] SLOPE_RST  = 16'd5240;

  typedef logic [SAMPLE_BITS-1:0] smp_t;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PH_OFFSET = 2'd0,
    REG_SLOPE     = 2'd1
  } reg_idx_t;

endpackage

@@ rtl/tmph_cell.sv @@
// One cell of the sorting chain: holds one sorted value and one drain slot.
module tmph_cell (
  input  logic               clk,
  input  tmph_pkg::smp_t     din,
  input  logic               occupied,
  input  logic               ins,
  input  tmph_pkg::smp_t     left_val,
  input  logic               left_gt,
  input  logic               load,
  input  logic               shift,
  input  tmph_pkg::smp_t     right_hold,
  output tmph_pkg::smp_t     val,
  output logic               gt,
  output tmph_pkg::smp_t     hold
);
  import tmph_pkg::*;

  smp_t val_next;

  // An empty cell counts as larger than any sample
  assign gt = !occupied || (val > din);

  // Larger values move one cell right; the new sample lands at the boundary
  always_comb begin
    if (gt) begin
      val_next = left_gt ? left_val : din;
    end else begin
      val_next = val;
    end
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      val <= val_next;
    end
  end

  // Drain row: snapshot of the finished batch, shifted toward cell zero
  always_ff @(posedge clk) begin
    if (load) begin
      hold <= val_next;
    end else if (shift) begin
      hold <= right_hold;
    end
  end

endmodule

@@ rtl/tmph_chain.sv @@
// Row of sorting cells with the batch fill counter.
module tmph_chain (
  input  logic           clk,
  input  logic           rst,
  input  logic           ins,
  input  tmph_pkg::smp_t din,
  input  logic           shift,
  output logic           load,
  output tmph_pkg::smp_t head
);
  import tmph_pkg::*;

  logic [CNT_W-1:0] fill_count;
  smp_t val  [BATCH_SIZE];
  smp_t hold [BATCH_SIZE];
  logic gt   [BATCH_SIZE];

  // Last sample of a batch snapshots the sorted row into the drain row
  assign load = ins && (fill_count == CNT_W'(BATCH_SIZE - 1));
  assign head = hold[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (ins) begin
      fill_count <= load ? '0 : fill_count + 1'b1;
    end
  end

  // Cells, each linked to its neighbors
  for (genvar i = 0; i < BATCH_SIZE; i++) begin : g_cell
    tmph_cell u_cell (
      .clk        (clk),
      .din        (din),
      .occupied   (fill_count > CNT_W'(i)),
      .ins        (ins),
      .left_val   ((i == 0) ? smp_t'(0) : val[(i == 0) ? 0 : i - 1]),
      .left_gt    ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .load       (load),
      .shift      (shift),
      .right_hold ((i == BATCH_SIZE - 1) ? smp_t'(0)
                                         : hold[(i == BATCH_SIZE - 1) ? i : i + 1]),
      .val        (val[i]),
      .gt         (gt[i]),
      .hold       (hold[i])
    );
  end

endmodule

@@ rtl/tmph_conv.sv @@
// Drains the sorted batch, sums the kept window and converts to pH.
module tmph_conv (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  tmph_pkg::smp_t                    head,
  input  logic [tmph_pkg::PH_W-1:0]         ph_offset,
  input  logic [tmph_pkg::SLOPE_W-1:0]      slope,
  output logic                              shift,
  output logic                              done,
  output logic [tmph_pkg::OUT_SUM_W-1:0]    trimmed_sum,
  output logic [tmph_pkg::PH_W-1:0]         ph_centi
);
  import tmph_pkg::*;

  logic             active;
  logic [CNT_W-1:0] idx;
  logic [SUM_W-1:0] acc;
  logic [SUM_W-1:0] acc_next;
  logic             keep;
  logic             last;

  logic                 sum_vld;
  logic [OUT_SUM_W-1:0] sum_q;
  logic [31:0]          acc_ext;

  logic                 prod_vld;
  logic [OUT_SUM_W-1:0] prod_sum;
  logic [31:0]          prod;
  logic [15:0]          drop;

  assign shift = active;

  // Drain sequencer: one sorted value per cycle from cell zero
  assign keep     = (idx >= CNT_W'(KEEP_LO)) && (32'(idx) < 32'(KEEP_HI));
  assign last     = (idx == CNT_W'(BATCH_SIZE - 1));
  assign acc_next = keep ? acc + SUM_W'(head) : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      idx    <= '0;
    end else if (load) begin
      active <= 1'b1;
      idx    <= '0;
    end else if (active) begin
      active <= !last;
      idx    <= last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc <= '0;
    end else if (active) begin
      acc <= acc_next;
    end
  end

  // Saturated sum
  assign acc_ext = 32'(acc_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_vld <= 1'b0;
    end else begin
      sum_vld <= active && last;
    end
  end

  always_ff @(posedge clk) begin
    if (active && last) begin
      sum_q <= (acc_ext > SUM_MAX) ? OUT_SUM_W'(SUM_MAX) : acc_ext[OUT_SUM_W-1:0];
    end
  end

  // Product with rounding half
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= sum_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_vld) begin
      prod     <= 32'(sum_q) * 32'(slope) + ROUND_HALF;
      prod_sum <= sum_q;
    end
  end

  // Offset minus drop, clamped at zero
  assign drop = prod[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_vld) begin
      trimmed_sum <= prod_sum;
      if (drop >= 16'(ph_offset)) begin
        ph_centi <= '0;
      end else begin
        ph_centi <= ph_offset - drop[PH_W-1:0];
      end
    end
  end

endmodule

@@ rtl/trimmed_mean_ph_conversion_top.sv @@
// Top level of the trimmed-mean pH converter.
//
//  channel   transfer             signals
//  input     start & !busy        sample
//  result    done (one cycle)     trimmed_sum, ph_centi
//  config    cfg_we               cfg_index, cfg_data
//
// One sample is taken every cycle that start is high; the cell row inserts it in sorted order.
// The last sample of a batch snapshots the row into the drain row; the sum is
// drained one cell per cycle, then registered as a saturated sum, a rounded product
// and the pH result, which is shown with the done pulse.
// busy stays low: a new batch fills while the previous one drains.
// Reset clears the fill count and pipeline flags and restores the registers.
module trimmed_mean_ph_conversion_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [tmph_pkg::IN_W-1:0]            sample,
  input  logic                                 cfg_we,
  input  logic [tmph_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tmph_pkg::CFG_W-1:0]           cfg_data,
  output logic                                 done,
  output logic [tmph_pkg::OUT_SUM_W-1:0]       trimmed_sum,
  output logic [tmph_pkg::PH_W-1:0]            ph_centi
);
  import tmph_pkg::*;

  logic                ins;
  logic                load;
  logic                shift;
  smp_t                head;
  logic [PH_W-1:0]     ph_offset;
  logic [SLOPE_W-1:0]  slope;

  assign busy = 1'b0;
  assign ins  = start && !busy;

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      ph_offset <= OFFSET_RST;
      slope     <= SLOPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PH_OFFSET: ph_offset <= cfg_data[PH_W-1:0];
        REG_SLOPE:     slope     <= cfg_data[SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  tmph_chain u_chain (
    .clk   (clk),
    .rst   (rst),
    .ins   (ins),
    .din   (sample[SAMPLE_BITS-1:0]),
    .shift (shift),
    .load  (load),
    .head  (head)
  );

  tmph_conv u_conv (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .head        (head),
    .ph_offset   (ph_offset),
    .slope       (slope),
    .shift       (shift),
    .done        (done),
    .trimmed_sum (trimmed_sum),
    .ph_centi    (ph_centi)
  );

endmodule

@@ test/tb_trimmed_mean_ph_conversion_top.sv @@
// Self-checking testbench for the trimmed-mean pH converter: batches of samples in, pH readings out.
`timescale 1ns / 1ps

module tb_trimmed_mean_ph_conversion_top;
  import tmph_pkg::*;

  // Register indexes that map to nothing; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam smp_t SMP_MAX = {SAMPLE_BITS{1'b1}};
  // Drain margin: done trails the last sample of a batch through the drain and the conversion registers
  localparam int DRAIN_CYCLES = BATCH_SIZE + 3 + 6;
  localparam int unsigned CYCLE_LIMIT = 60000;

  typedef struct packed {
    logic [OUT_SUM_W-1:0] sum;
    logic [PH_W-1:0]      ph;
  } ph_reading_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [IN_W-1:0]      sample = '0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 done;
  logic [OUT_SUM_W-1:0] trimmed_sum;
  logic [PH_W-1:0]      ph_centi;

  // Pending samples, predicted readings and the predictor's own state
  logic [IN_W-1:0] sample_q[$];
  ph_reading_t     readings_due[$];
  smp_t            batch_buf [BATCH_SIZE];
  int              batch_fill = 0;
  logic [PH_W-1:0]    offset_now = OFFSET_RST;
  logic [SLOPE_W-1:0] slope_now  = SLOPE_RST;

  int          idle_pct = 26;
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  ph_reading_t want;

  trimmed_mean_ph_conversion_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .sample      (sample),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .trimmed_sum (trimmed_sum),
    .ph_centi    (ph_centi)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Store one accepted sample; on the last of a batch, sort, trim, sum and convert
  task automatic take_sample(input logic [IN_W-1:0] raw);
    smp_t            row [BATCH_SIZE];
    smp_t            key;
    int              i;
    int              j;
    logic [31:0]     total;
    logic [47:0]     drop;
    ph_reading_t     r;
    if (batch_fill >= BATCH_SIZE) batch_fill = 0;
    batch_buf[batch_fill] = raw[SAMPLE_BITS-1:0];
    batch_fill++;
    if (batch_fill < BATCH_SIZE) return;
    batch_fill = 0;
    row = batch_buf;
    for (i = 1; i < BATCH_SIZE; i++) begin
      key = row[i];
      j = i - 1;
      while (j >= 0 && row[j] > key) begin
        row[j + 1] = row[j];
        j--;
      end
      row[j + 1] = key;
    end
    total = '0;
    for (i = KEEP_LO; i < KEEP_HI; i++) total += row[i];
    if (total > SUM_MAX) total = SUM_MAX;
    // Q16 product, halves round up
    drop = ({16'd0, total} * slope_now + 48'(ROUND_HALF)) >> 16;
    r.sum = total[OUT_SUM_W-1:0];
    r.ph  = (drop >= offset_now) ? '0 : offset_now - drop[PH_W-1:0];
    readings_due.push_back(r);
  endtask

  // Input driver: holds start until the transfer, idles at random between items
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) take_sample(sample);
      if (!start || !busy) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start  <= 1'b1;
          sample <= sample_q.pop_front();
        end else begin
          start  <= 1'b0;
          sample <= IN_W'($urandom);
        end
      end
    end
  end

  // Result monitor: every done pulse must match the oldest predicted reading
  always @(posedge clk) begin
    if (!rst && done !== 1'b0) begin
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected result trimmed_sum=%0d ph_centi=%0d",
                 $time, trimmed_sum, ph_centi);
        mismatches++;
      end else begin
        want = readings_due.pop_front();
        if (trimmed_sum !== want.sum) begin
          $display("%0t: trimmed_sum mismatch expected=%0d actual=%0d",
                   $time, want.sum, trimmed_sum);
          mismatches++;
        end
        if (ph_centi !== want.ph) begin
          $display("%0t: ph_centi mismatch expected=%0d actual=%0d",
                   $time, want.ph, ph_centi);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("trimmed_mean_ph_conversion_top regression: fail");
      $finish;
    end
  end

  // Wait until every sample is taken and every reading is out, then let the pipe drain
  task automatic wait_idle();
    do @(negedge clk);
    while (sample_q.size() != 0 || start || readings_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_PH_OFFSET: offset_now = data[PH_W-1:0];
      REG_SLOPE:     slope_now  = data[SLOPE_W-1:0];
      default: ;
    endcase
  endtask

  // Program both registers plus one stray write to an unmapped index
  task automatic program_regs(input logic [CFG_W-1:0] off_word,
                              input logic [CFG_W-1:0] slope_word);
    write_reg(REG_PH_OFFSET, off_word);
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
    write_reg(REG_SLOPE, slope_word);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Mix of full-range values, tight clusters (lots of ties) and extremes
  task automatic queue_mixed_samples(input int count);
    int   k;
    int   pick;
    int   v;
    smp_t center;
    center = '0;
    for (k = 0; k < count; k++) begin
      if (k % BATCH_SIZE == 0) center = smp_t'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        v = $urandom_range(0, SMP_MAX);
      end else if (pick < 80) begin
        v = int'(center) + $urandom_range(0, 63) - 32;
        if (v < 0) v = 0;
        if (v > SMP_MAX) v = SMP_MAX;
      end else begin
        case ($urandom_range(0, 3))
          0: v = 0;
          1: v = 1;
          2: v = SMP_MAX - 1;
          default: v = SMP_MAX;
        endcase
      end
      sample_q.push_back(IN_W'(v));
    end
  endtask

  initial begin
    smp_t spread [BATCH_SIZE] = '{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd2048,
                                  12'd1, 12'd4094, 12'd2047, 12'd3000, 12'd100};
    int   k;
    int   p;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset-value registers, a spread batch with ties, an all-max batch,
    // then half a batch that completes after the registers change
    foreach (spread[k]) sample_q.push_back(spread[k]);
    for (k = 0; k < BATCH_SIZE; k++) sample_q.push_back(SMP_MAX);
    sample_q.push_back(12'h555);
    sample_q.push_back(12'hAAA);
    sample_q.push_back(12'h000);
    sample_q.push_back(SMP_MAX);
    sample_q.push_back(12'h800);

    // Random phases, register extremes first; phase 3 runs without idle gaps
    for (p = 0; p < 8; p++) begin
      wait_idle();
      idle_pct = (p == 3) ? 0 : 26;
      case (p)
        0: program_regs(16'hF064, 16'hFFFF);      // small offset, steep slope: clamps at zero
        1: program_regs(16'h0000, 16'h0000);
        2: program_regs(16'hFFFF, 16'h0000);
        3: program_regs(16'h0FFF, 16'hFFFF);
        default: program_regs(CFG_W'($urandom),
                              $urandom_range(0, 1) ? CFG_W'($urandom)
                                                   : CFG_W'($urandom_range(0, 8191)));
      endcase
      queue_mixed_samples((p == 3) ? 150 : $urandom_range(100, 125));
    end
    wait_idle();

    if (mismatches == 0) begin
      $display("trimmed_mean_ph_conversion_top regression: pass");
    end else begin
      $display("trimmed_mean_ph_conversion_top regression: fail");
    end
    $finish;
  end

endmodule
